>>> sv/pma_pkg.sv
// package: constants, register codes and widths for the priority motion arbiter
`default_nettype none
package pma_pkg;

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WHEEL   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_FACTOR = 2'd3;

    // register widths
    localparam int CFG_DATA_W    = 15;
    localparam int SLOT_COUNT_W  = 5;
    localparam int MAX_WHEEL_W   = 15;
    localparam int TURN_FACTOR_W = 10;

    // reset values
    localparam logic [SLOT_COUNT_W-1:0]  RST_SLOT_COUNT  = 5'd16;
    localparam logic [MAX_WHEEL_W-1:0]   RST_MAX_WHEEL   = 15'd900;
    localparam logic [TURN_FACTOR_W-1:0] RST_TURN_FACTOR = 10'd225;

    // payload widths
    localparam int SLOT_W  = 4;
    localparam int SPEED_W = 16;

    // rotation is Q3.12, so the turn term carries 12 fraction bits
    localparam int FRAC_W = 12;
    localparam int PROD_W = TURN_FACTOR_W + 1 + SPEED_W;

    // default number of priority slots
    localparam int SLOTS_DEF = 16;

endpackage : pma_pkg
`default_nettype wire

>>> sv/pma_if.sv
// interfaces: request and result channels of the priority motion arbiter
`default_nettype none
interface pma_req_if
    import pma_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [SLOT_W-1:0]         slot;
    logic                      active;
    logic signed [SPEED_W-1:0] translation;
    logic signed [SPEED_W-1:0] rotation;

    modport source (output valid, slot, active, translation, rotation, input ready);
    modport sink   (input valid, slot, active, translation, rotation, output ready);
endinterface : pma_req_if

interface pma_res_if
    import pma_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic                      drive_issued;
    logic signed [SPEED_W-1:0] drive_translation;
    logic signed [SPEED_W-1:0] drive_rotation;
    logic [SLOT_W-1:0]         winner_slot;
    logic                      none_active;

    modport source (output valid, drive_issued, drive_translation, drive_rotation,
                    winner_slot, none_active, input ready);
    modport sink   (input valid, drive_issued, drive_translation, drive_rotation,
                    winner_slot, none_active, output ready);
endinterface : pma_res_if
`default_nettype wire

>>> sv/pma_clamp.sv
// wheel clamp: limits translation so that translation plus turn term stays under max_wheel
`default_nettype none
module pma_clamp
    import pma_pkg::*;
(
    input  wire logic signed [SPEED_W-1:0]     speed,
    input  wire logic signed [PROD_W-1:0]      term,
    input  wire logic        [MAX_WHEEL_W-1:0] max_wheel,
    output logic signed [SPEED_W-1:0]          speed_out
);

    localparam int SUM_W = SPEED_W + FRAC_W + 1;
    localparam int Q_W   = SUM_W - FRAC_W;
    localparam logic signed [SUM_W-1:0] RND = SUM_W'((1 << FRAC_W) - 1);
    localparam logic signed [Q_W-1:0]   SMAX = Q_W'((1 << (SPEED_W - 1)) - 1);
    localparam logic signed [Q_W-1:0]   SMIN = -(Q_W'(1 << (SPEED_W - 1)));

    logic signed [SUM_W-1:0] lhs;
    logic signed [SUM_W-1:0] limit;
    logic signed [SUM_W-1:0] diff;
    logic signed [SUM_W-1:0] diff_rnd;
    logic signed [Q_W-1:0]   quot;

    // scaled compare and the limited speed, truncated toward zero
    always_comb
    begin
        lhs      = (SUM_W'(speed) <<< FRAC_W) + SUM_W'(term);
        limit    = $signed({{(SUM_W-MAX_WHEEL_W-FRAC_W){1'b0}}, max_wheel, {FRAC_W{1'b0}}});
        diff     = limit - SUM_W'(term);
        diff_rnd = diff[SUM_W-1] ? diff + RND : diff;
        quot     = Q_W'(diff_rnd >>> FRAC_W);
        if (lhs > limit)
        begin
            if (quot > SMAX)
                speed_out = SMAX[SPEED_W-1:0];
            else if (quot < SMIN)
                speed_out = SMIN[SPEED_W-1:0];
            else
                speed_out = quot[SPEED_W-1:0];
        end
        else
        begin
            speed_out = speed;
        end
    end

endmodule : pma_clamp
`default_nettype wire

>>> sv/priority_motion_arbiter.sv
// top level: fixed-priority arbiter over behavior motion requests
//
// Requests come in on req (valid/ready). Each one is stored in its priority
// slot; the lowest-numbered active slot below slot_count then wins. A result
// leaves on res (valid/ready) for each request taken while enabled with an
// in-range slot; other requests are dropped in the accept cycle.
// The sequencer steps through an accept, a scan over the valid bits
// (8 slots a cycle), the slot-memory read, a multiply, a clamp and the
// done state, which loads the output register. A winner found in the
// first group of 8 ends the scan early.
// req.ready is high only while the sequencer idles, so one request is in
// work at a time; the next can be taken while a result waits on res.
// A stall on res holds the finished result in the sequencer until the
// output register frees up; req stays low meanwhile.
// Reset clears all slot valid bits and the current velocity at once and
// loads register defaults (disabled, 16 slots, max_wheel 900, factor 225).
// Configuration writes are taken at any cycle through cfg_we/cfg_index.
`default_nettype none
module priority_motion_arbiter
    import pma_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    pma_req_if.sink                    req,
    pma_res_if.source                  res
);

    localparam int GROUP   = 8;
    localparam int NGROUPS = (SLOTS + GROUP - 1) / GROUP;
    localparam int PAD     = NGROUPS * GROUP;
    localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
    localparam int CW      = ($clog2(PAD + 1) > SLOT_COUNT_W) ? $clog2(PAD + 1) : SLOT_COUNT_W;
    localparam int JW      = $clog2(GROUP);
    localparam logic [GW-1:0] LAST_GRP = GW'(NGROUPS - 1);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_MUL   = 6'b001000,
        ST_CLAMP = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                      enable_reg;
    logic [SLOT_COUNT_W-1:0]   slot_count_reg;
    logic [MAX_WHEEL_W-1:0]    max_wheel_reg;
    logic [TURN_FACTOR_W-1:0]  turn_factor_reg;

    logic [SLOTS-1:0]          valid_reg;
    logic [2*SPEED_W-1:0]      mem_reg [SLOTS];
    logic [2*SPEED_W-1:0]      rd_reg;
    logic [GW-1:0]             grp_reg;
    logic [CW-1:0]             win_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [SPEED_W-1:0] cur_speed_reg;
    logic signed [SPEED_W-1:0] cur_turn_reg;

    // pending result, waits here for the output register
    logic                      pend_issued_reg;
    logic signed [SPEED_W-1:0] pend_trans_reg;
    logic signed [SPEED_W-1:0] pend_rot_reg;
    logic [SLOT_W-1:0]         pend_slot_reg;
    logic                      pend_none_reg;

    logic                      res_valid_reg;
    logic                      res_issued_reg;
    logic signed [SPEED_W-1:0] res_trans_reg;
    logic signed [SPEED_W-1:0] res_rot_reg;
    logic [SLOT_W-1:0]         res_slot_reg;
    logic                      res_none_reg;

    logic [CW-1:0]             count_eff;
    logic [CW-1:0]             slot_ext;
    logic                      req_fire;
    logic                      req_take;
    logic [PAD-1:0]            valid_pad;
    logic [GROUP-1:0]          grp_bits;
    logic [CW-1:0]             grp_base;
    logic                      grp_hit;
    logic [JW-1:0]             grp_sel;
    logic signed [SPEED_W-1:0] rd_speed;
    logic signed [SPEED_W-1:0] rd_turn;
    logic signed [SPEED_W-1:0] clamped;
    logic                      vel_change;
    logic                      out_free;

    // effective slot count and request qualification
    always_comb
    begin
        count_eff = (CW'(slot_count_reg) > SLOTS_C) ? SLOTS_C : CW'(slot_count_reg);
        slot_ext  = CW'(req.slot);
        req_fire  = req.valid && req.ready;
        req_take  = req_fire && enable_reg && (slot_ext < count_eff);
        out_free  = !res_valid_reg || res.ready;
    end

    // priority scan over one group of valid bits
    always_comb
    begin
        valid_pad = PAD'(valid_reg);
        grp_base  = CW'(grp_reg) << JW;
        grp_bits  = valid_pad[grp_reg*GROUP +: GROUP];
        for (int j = 0; j < GROUP; j++)
        begin
            if ((grp_base + CW'(j)) >= count_eff)
                grp_bits[j] = 1'b0;
        end
        grp_hit = |grp_bits;
        grp_sel = '0;
        for (int j = GROUP - 1; j >= 0; j--)
        begin
            if (grp_bits[j])
                grp_sel = JW'(j);
        end
    end

    assign rd_speed   = $signed(rd_reg[2*SPEED_W-1:SPEED_W]);
    assign rd_turn    = $signed(rd_reg[SPEED_W-1:0]);
    assign vel_change = (rd_speed != cur_speed_reg) || (rd_turn != cur_turn_reg);

    pma_clamp u_clamp (
        .speed     (rd_speed),
        .term      (prod_reg),
        .max_wheel (max_wheel_reg),
        .speed_out (clamped)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg      <= 1'b0;
            slot_count_reg  <= RST_SLOT_COUNT;
            max_wheel_reg   <= RST_MAX_WHEEL;
            turn_factor_reg <= RST_TURN_FACTOR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ENABLE:      enable_reg      <= cfg_wdata[0];
                CFG_SLOT_COUNT:  slot_count_reg  <= cfg_wdata[SLOT_COUNT_W-1:0];
                CFG_MAX_WHEEL:   max_wheel_reg   <= cfg_wdata[MAX_WHEEL_W-1:0];
                CFG_TURN_FACTOR: turn_factor_reg <= cfg_wdata[TURN_FACTOR_W-1:0];
                default:         ;
            endcase
        end
    end

    // slot memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (req_take)
            mem_reg[slot_ext[AW-1:0]] <= {req.translation, req.rotation};
        if (state_reg == ST_READ)
            rd_reg <= mem_reg[win_reg[AW-1:0]];
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (req_take) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (grp_hit)
                    state_next = ST_READ;
                else if (grp_reg == LAST_GRP)
                    state_next = ST_DONE;
            end
            ST_READ:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_CLAMP;
            ST_CLAMP: state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // control state: sequencer, valid bits, current velocity, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            cur_speed_reg <= '0;
            cur_turn_reg  <= '0;
            res_valid_reg <= 1'b0;
            grp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req_take)
            begin
                valid_reg[slot_ext[AW-1:0]] <= req.active;
                grp_reg                     <= '0;
            end
            else if (state_reg == ST_SCAN && !grp_hit && grp_reg != LAST_GRP)
            begin
                grp_reg <= grp_reg + GW'(1);
            end
            if (state_reg == ST_SCAN && !grp_hit && grp_reg == LAST_GRP)
            begin
                cur_speed_reg <= '0;
                cur_turn_reg  <= '0;
            end
            else if (state_reg == ST_CLAMP && vel_change)
            begin
                cur_speed_reg <= rd_speed;
                cur_turn_reg  <= rd_turn;
            end
            if (state_reg == ST_DONE && out_free)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath: winner, product, pending result, output payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN && grp_hit)
            win_reg <= grp_base + CW'(grp_sel);
        if (state_reg == ST_MUL)
            prod_reg <= PROD_W'($signed({1'b0, turn_factor_reg}) * rd_turn);
        if (state_reg == ST_SCAN && !grp_hit && grp_reg == LAST_GRP)
        begin
            pend_issued_reg <= 1'b1;
            pend_trans_reg  <= '0;
            pend_rot_reg    <= '0;
            pend_slot_reg   <= '0;
            pend_none_reg   <= 1'b1;
        end
        else if (state_reg == ST_CLAMP)
        begin
            pend_issued_reg <= vel_change;
            pend_trans_reg  <= vel_change ? clamped : '0;
            pend_rot_reg    <= vel_change ? rd_turn : '0;
            pend_slot_reg   <= win_reg[SLOT_W-1:0];
            pend_none_reg   <= 1'b0;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            res_issued_reg <= pend_issued_reg;
            res_trans_reg  <= pend_trans_reg;
            res_rot_reg    <= pend_rot_reg;
            res_slot_reg   <= pend_slot_reg;
            res_none_reg   <= pend_none_reg;
        end
    end

    assign req.ready             = (state_reg == ST_IDLE);
    assign res.valid             = res_valid_reg;
    assign res.drive_issued      = res_issued_reg;
    assign res.drive_translation = res_trans_reg;
    assign res.drive_rotation    = res_rot_reg;
    assign res.winner_slot       = res_slot_reg;
    assign res.none_active       = res_none_reg;

    // a new result only comes out of the done state
    a_res_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside done state");

    // a qualified request always starts a scan
    a_take_scans: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> state_reg == ST_SCAN)
        else $error("accepted request did not start scan");

    // when the slot memory is read, at least one slot is active
    a_win_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ |-> PAD'(valid_reg) != '0)
        else $error("winner read with no valid slot");

    // a stop result carries zero drive fields and an issued command
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_none_reg) |->
            (res_issued_reg && res_trans_reg == '0 && res_rot_reg == '0))
        else $error("stop result with nonzero drive");

endmodule : priority_motion_arbiter
`default_nettype wire

>>> tb/sv/pma_checker.sv
`timescale 1ns / 100ps
// checker: mirrors the registers, predicts each motion command and compares it
module pma_checker
    import pma_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    pma_req_if                         req,
    pma_res_if                         res,
    output int                         fail_count,
    output int                         pending,
    output int                         checked
);

    typedef struct packed {
        logic                      drive_issued;
        logic signed [SPEED_W-1:0] drive_translation;
        logic signed [SPEED_W-1:0] drive_rotation;
        logic [SLOT_W-1:0]         winner_slot;
        logic                      none_active;
    } motion_cmd_t;

    // commands predicted but not yet seen on res
    motion_cmd_t cmd_q[$];
    motion_cmd_t want;

    // register mirror
    logic                     arb_enable;
    logic [SLOT_COUNT_W-1:0]  arb_slot_count;
    logic [MAX_WHEEL_W-1:0]   arb_max_wheel;
    logic [TURN_FACTOR_W-1:0] arb_turn_factor;

    // slot store and last commanded (unclamped) velocity
    logic                      slot_live  [SLOTS];
    logic signed [SPEED_W-1:0] slot_trans [SLOTS];
    logic signed [SPEED_W-1:0] slot_rot   [SLOTS];
    logic signed [SPEED_W-1:0] cur_trans;
    logic signed [SPEED_W-1:0] cur_rot;

    task automatic report_error(input string msg);
        $display("[%0t] checker: %s", $time, msg);
        fail_count++;
    endtask

    // limit translation so that translation plus the turn term stays under max_wheel
    function automatic logic signed [SPEED_W-1:0] wheel_clamp(
        input logic signed [SPEED_W-1:0] trans,
        input logic signed [SPEED_W-1:0] rot
    );
        longint term;
        longint lim;
        longint q;
        term = longint'(arb_turn_factor) * longint'(rot);
        lim  = longint'(arb_max_wheel) * 4096;
        if (longint'(trans) * 4096 + term > lim)
        begin
            q = (lim - term) / 4096;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[SPEED_W-1:0];
        end
        return trans;
    endfunction

    // for an enabled, in-range request: store it, pick the winner and queue the expected command
    task automatic arbitrate(
        input logic [SLOT_W-1:0]         s,
        input logic                      act,
        input logic signed [SPEED_W-1:0] tr,
        input logic signed [SPEED_W-1:0] rt
    );
        int          count;
        int          win;
        motion_cmd_t cmd;
        count = (int'(arb_slot_count) > SLOTS) ? SLOTS : int'(arb_slot_count);
        if (!arb_enable || int'(s) >= count)
            return;
        slot_live[s]  = act;
        slot_trans[s] = tr;
        slot_rot[s]   = rt;
        win = -1;
        for (int k = count - 1; k >= 0; k--)
        begin
            if (slot_live[k])
                win = k;
        end
        cmd = '0;
        if (win < 0)
        begin
            // nobody wants control: stop
            cmd.drive_issued = 1'b1;
            cmd.none_active  = 1'b1;
            cur_trans = '0;
            cur_rot   = '0;
        end
        else
        begin
            cmd.winner_slot = win[SLOT_W-1:0];
            if (slot_trans[win] != cur_trans || slot_rot[win] != cur_rot)
            begin
                cmd.drive_issued      = 1'b1;
                cmd.drive_translation = wheel_clamp(slot_trans[win], slot_rot[win]);
                cmd.drive_rotation    = slot_rot[win];
                cur_trans = slot_trans[win];
                cur_rot   = slot_rot[win];
            end
        end
        cmd_q.push_back(cmd);
    endtask

    // watch both channels and the register port
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arb_enable      = 1'b0;
            arb_slot_count  = RST_SLOT_COUNT;
            arb_max_wheel   = RST_MAX_WHEEL;
            arb_turn_factor = RST_TURN_FACTOR;
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_live[k]  = 1'b0;
                slot_trans[k] = '0;
                slot_rot[k]   = '0;
            end
            cur_trans  = '0;
            cur_rot    = '0;
            cmd_q.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            // compare an accepted command against the oldest prediction
            if (res.valid && res.ready)
            begin
                if (cmd_q.size() == 0)
                    report_error($sformatf("command with no request waiting, slot %0d",
                                           res.winner_slot));
                else
                begin
                    want = cmd_q.pop_front();
                    checked++;
                    if (res.drive_issued !== want.drive_issued)
                        report_error($sformatf("drive_issued got %0b want %0b",
                                               res.drive_issued, want.drive_issued));
                    if (res.drive_translation !== want.drive_translation)
                        report_error($sformatf("drive_translation got %0d want %0d",
                                               res.drive_translation, want.drive_translation));
                    if (res.drive_rotation !== want.drive_rotation)
                        report_error($sformatf("drive_rotation got %0d want %0d",
                                               res.drive_rotation, want.drive_rotation));
                    if (res.winner_slot !== want.winner_slot)
                        report_error($sformatf("winner_slot got %0d want %0d",
                                               res.winner_slot, want.winner_slot));
                    if (res.none_active !== want.none_active)
                        report_error($sformatf("none_active got %0b want %0b",
                                               res.none_active, want.none_active));
                end
            end

            // new request
            if (req.valid && req.ready)
                arbitrate(req.slot, req.active, req.translation, req.rotation);

            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ENABLE:      arb_enable      = cfg_wdata[0];
                    CFG_SLOT_COUNT:  arb_slot_count  = cfg_wdata[SLOT_COUNT_W-1:0];
                    CFG_MAX_WHEEL:   arb_max_wheel   = cfg_wdata[MAX_WHEEL_W-1:0];
                    CFG_TURN_FACTOR: arb_turn_factor = cfg_wdata[TURN_FACTOR_W-1:0];
                    default: ;
                endcase
            end

            pending = cmd_q.size();
        end
    end

endmodule : pma_checker

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// testbench top: clock, reset, request and register stimulus, verdict
module tb;
    import pma_pkg::*;

    localparam int ITEMS       = 850;
    localparam int PHASE_ITEMS = 85;
    localparam int SETTLE      = 16;
    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    pma_req_if req_if ();
    pma_res_if res_if ();

    int fail_count;
    int pending;
    int checked;

    int req_idle_pct = 38;
    int res_idle_pct = 38;
    int res_hold     = 0;
    int quiet        = 0;
    int useful       = 0;
    int dropped      = 0;
    int settings     = 0;

    // shadow of enable and effective slot count, for counting arbitrated requests
    logic sh_enable = 1'b0;
    int   sh_count  = 16;

    // last velocity sent per slot, reused to hit the unchanged-winner case
    logic signed [SPEED_W-1:0] last_tr [16];
    logic signed [SPEED_W-1:0] last_rt [16];

    priority_motion_arbiter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .res       (res_if)
    );

    pma_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .req        (req_if),
        .res        (res_if),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // result side: random stalls, plus a long hold-off when asked
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (res_hold > 0)
            begin
                res_if.ready = 1'b0;
                res_hold--;
            end
            else
                res_if.ready = ($urandom_range(0, 99) >= res_idle_pct);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles, %0d commands outstanding",
                     quiet, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic signed [SPEED_W-1:0] pick_speed();
        logic [31:0] r;
        r = $urandom();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            2: return SPEED_W'($urandom_range(0, 600)) - 16'sd300;
            default: return r[SPEED_W-1:0];
        endcase
    endfunction

    // offer one request, with random gaps before it, and wait for the handshake
    task automatic send_req(
        input logic [SLOT_W-1:0]         s,
        input logic                      act,
        input logic signed [SPEED_W-1:0] tr,
        input logic signed [SPEED_W-1:0] rt
    );
        @(negedge clk);
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_if.valid = 1'b0;
            @(negedge clk);
        end
        req_if.valid       = 1'b1;
        req_if.slot        = s;
        req_if.active      = act;
        req_if.translation = tr;
        req_if.rotation    = rt;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (sh_enable && int'(s) < sh_count)
            useful++;
        else
            dropped++;
    endtask

    // drop valid and wait until every expected command has come out
    task automatic drain();
        @(negedge clk);
        req_if.valid = 1'b0;
        wait (pending == 0);
    endtask

    // register write, only once the block has gone idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        drain();
        repeat (SETTLE) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val[CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_ENABLE:     sh_enable = val[0];
            CFG_SLOT_COUNT: sh_count  = (val[4:0] > 16) ? 16 : int'(val[4:0]);
            default: ;
        endcase
        settings++;
    endtask

    // random request, slot from 0 to slot_count plus one (at most 15), so some fall outside slot_count
    task automatic send_random();
        int                        top;
        logic [SLOT_W-1:0]         s;
        logic                      act;
        logic signed [SPEED_W-1:0] tr;
        logic signed [SPEED_W-1:0] rt;
        top = (sh_count < 15) ? sh_count + 1 : 15;
        s   = SLOT_W'($urandom_range(0, top));
        act = ($urandom_range(0, 99) < 60);
        if ($urandom_range(0, 3) == 0)
        begin
            tr = last_tr[s];
            rt = last_rt[s];
        end
        else
        begin
            tr = pick_speed();
            rt = pick_speed();
        end
        last_tr[s] = tr;
        last_rt[s] = rt;
        send_req(s, act, tr, rt);
    endtask

    // main sequence
    initial
    begin
        int counts [8];
        int phase;
        int start;
        int sent;

        counts             = '{16, 1, 31, 8, 15, 4, 17, 16};
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_ENABLE;
        cfg_wdata          = '0;
        req_if.valid       = 1'b0;
        req_if.slot        = '0;
        req_if.active      = 1'b0;
        req_if.translation = '0;
        req_if.rotation    = '0;
        for (int k = 0; k < 16; k++)
        begin
            last_tr[k] = '0;
            last_rt[k] = '0;
        end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // disabled after reset: requests dropped
        send_req(4'd0, 1'b1, 16'sd100, 16'sd0);
        send_req(4'd15, 1'b1, -16'sd1, -16'sd1);
        write_reg(CFG_ENABLE, 1);

        // default wheel limits: new winner, unchanged winner, clamp, stop
        send_req(4'd0, 1'b1, 16'sd100, 16'sd0);
        send_req(4'd0, 1'b1, 16'sd100, 16'sd0);
        send_req(4'd5, 1'b1, 16'sd32767, 16'sd32767);
        send_req(4'd0, 1'b0, 16'sd0, 16'sd0);
        send_req(4'd5, 1'b1, -16'sd32768, -16'sd32768);
        send_req(4'd15, 1'b1, 16'sd0, 16'sd0);
        send_req(4'd5, 1'b0, 16'sd0, 16'sd0);
        send_req(4'd15, 1'b0, 16'sd0, 16'sd0);
        send_req(4'd3, 1'b0, 16'sd0, 16'sd0);

        // zero wheel limit, largest turn factor
        write_reg(CFG_MAX_WHEEL, 0);
        write_reg(CFG_TURN_FACTOR, 1023);
        send_req(4'd2, 1'b1, 16'sd1, 16'sd0);
        send_req(4'd2, 1'b1, -16'sd1, -16'sd32768);
        send_req(4'd2, 1'b1, 16'sd32767, 16'sd32767);

        // largest wheel limit, no turn term
        write_reg(CFG_MAX_WHEEL, 32767);
        write_reg(CFG_TURN_FACTOR, 0);
        send_req(4'd2, 1'b1, 16'sd32767, -16'sd32768);
        send_req(4'd1, 1'b1, -16'sd32768, 16'sd32767);

        // slot count below, at zero and above the slot array
        write_reg(CFG_SLOT_COUNT, 4);
        send_req(4'd7, 1'b1, 16'sd5, 16'sd5);
        send_req(4'd3, 1'b1, 16'sd5, 16'sd5);
        write_reg(CFG_SLOT_COUNT, 0);
        send_req(4'd0, 1'b1, 16'sd9, 16'sd9);
        write_reg(CFG_SLOT_COUNT, 31);
        send_req(4'd15, 1'b1, 16'sd20, 16'sd20);
        send_req(4'd1, 1'b0, 16'sd0, 16'sd0);

        // random phases, each under its own register setting
        phase = 0;
        while (useful < ITEMS)
        begin
            case (phase % 5)
                0:
                begin
                    write_reg(CFG_MAX_WHEEL, 0);
                    write_reg(CFG_TURN_FACTOR, 1023);
                end
                1:
                begin
                    write_reg(CFG_MAX_WHEEL, 32767);
                    write_reg(CFG_TURN_FACTOR, 0);
                end
                2:
                begin
                    write_reg(CFG_MAX_WHEEL, int'(RST_MAX_WHEEL));
                    write_reg(CFG_TURN_FACTOR, int'(RST_TURN_FACTOR));
                end
                default:
                begin
                    write_reg(CFG_MAX_WHEEL, $urandom_range(0, 32767));
                    write_reg(CFG_TURN_FACTOR, $urandom_range(0, 1023));
                end
            endcase
            write_reg(CFG_SLOT_COUNT, counts[phase % 8]);

            // a stretch with no idling on either side
            if (phase == 4)
            begin
                req_idle_pct = 0;
                res_idle_pct = 0;
            end
            else
            begin
                req_idle_pct = 38;
                res_idle_pct = 38;
            end

            // disabled for a while: everything dropped
            if (phase == 6)
            begin
                write_reg(CFG_ENABLE, 0);
                repeat (10) send_random();
                write_reg(CFG_ENABLE, 1);
            end

            start = useful;
            sent  = 0;
            while (useful - start < PHASE_ITEMS && sent < 300)
            begin
                send_random();
                sent++;
                // result side holds off while requests keep coming
                if (phase == 2 && sent == 5)
                    res_hold = HOLD_CYCLES;
                // sender pauses until the block has emptied out
                if (phase == 3 && sent == 40)
                    drain();
            end
            phase++;
        end

        // let everything drain, then wait a settle period for stray commands
        drain();
        repeat (SETTLE) @(posedge clk);
        $display("covered %0d arbitrated requests and %0d dropped ones over %0d register writes",
                 useful, dropped, settings);
        $display("%0d commands compared, with a long result hold-off and a no-idle stretch",
                 checked);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule : tb

>>> priority_motion_arbiter.f
sv/pma_pkg.sv
sv/pma_if.sv
sv/pma_clamp.sv
sv/priority_motion_arbiter.sv
tb/sv/pma_checker.sv
tb/sv/tb.sv
